// ===== rtl/core/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants for the I2C register-access master sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] ADDR_READ_BIT = 8'h01;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'd0,
        ST_START0   = 5'd1,
        ST_START1   = 5'd2,
        ST_START2   = 5'd3,
        ST_TX_SET   = 5'd4,
        ST_TX_HIGH  = 5'd5,
        ST_TX_LOW   = 5'd6,
        ST_ACK_REL  = 5'd7,
        ST_ACK_HIGH = 5'd8,
        ST_ACK_LOW  = 5'd9,
        ST_RX_REL   = 5'd10,
        ST_RX_HIGH  = 5'd11,
        ST_RX_LOW   = 5'd12,
        ST_RX_DRIVE = 5'd13,
        ST_MA_SET   = 5'd14,
        ST_MA_HIGH  = 5'd15,
        ST_MA_LOW   = 5'd16,
        ST_STOP     = 5'd17
    } step_t;

    typedef enum logic [1:0] {
        STG_ADDR  = 2'd0,
        STG_REG   = 2'd1,
        STG_DATA  = 2'd2,
        STG_RADDR = 2'd3
    } stage_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } lines_t;

    localparam lines_t LINES_REST = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
    localparam lines_t LINES_NACK = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};

    typedef struct packed {
        logic       busy;
        logic       success;
        logic       done;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } result_t;

endpackage

// ===== rtl/core/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access
// I2C master for register writes and reads, stepped by one tick word per cycle.
// ----------------------------------------------------------------------------
// a result word is registered as its input word is taken
// throughput: one word per cycle while no result waits on m_tready
// s_tready is low while a result waits on m_tready; a new word enters with its take
// reset: synchronous active-low aresetn; sequencer idle, bus resting at
// scl high, sda high driven, ticks_per_delay back to 1
module i2c_master_register_access (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // device_address, register_address, write_data, read_count, sda_in, pad
    input  logic [39:0] s_tdata,
    // action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_level, sda_level, sda_drive, read_byte, read_valid, done_res,
    // success, busy_res, pad
    output logic [15:0] m_tdata
);

    logic [9:0]              ticks_reg;
    i2cm_pkg::step_t         step_reg, step_next;
    logic [9:0]              phase_reg, phase_next;
    logic [2:0]              bit_reg, bit_next;
    logic [7:0]              shift_reg, shift_next;
    logic [7:0]              left_reg, left_next;
    logic [7:0]              dev_reg, dev_next;
    logic [7:0]              regaddr_reg, regaddr_next;
    logic [7:0]              wdata_reg, wdata_next;
    logic                    rd_reg, rd_next;
    i2cm_pkg::lines_t        lines_reg, lines_next;
    i2cm_pkg::stage_t        stage_reg, stage_next;
    logic                    nack_reg, nack_next;
    i2cm_pkg::result_t       res_reg, res_next;
    logic                    m_valid_reg;

    logic                    accept;
    logic [1:0]              action;
    logic                    sda_in;
    logic [9:0]              limit;
    logic [9:0]              phase_inc;
    i2cm_pkg::lines_t        lv;
    logic                    last_byte;

    assign action   = s_tuser;
    assign sda_in   = s_tdata[32];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg};
    assign limit    = (ticks_reg == 10'd0) ? 10'd1 : ticks_reg;

    always_comb begin
        step_next    = step_reg;
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        wdata_next   = wdata_reg;
        rd_next      = rd_reg;
        lines_next   = lines_reg;
        stage_next   = stage_reg;
        nack_next    = nack_reg;
        res_next     = '0;
        lv           = lines_reg;
        phase_inc    = '0;
        last_byte    = 1'b0;

        // command start
        if (step_reg == i2cm_pkg::ST_IDLE &&
            (action == i2cm_pkg::ACT_WRITE || action == i2cm_pkg::ACT_READ)) begin
            dev_next     = s_tdata[7:0];
            regaddr_next = s_tdata[15:8];
            wdata_next   = s_tdata[23:16];
            rd_next      = (action == i2cm_pkg::ACT_READ);
            left_next    = (s_tdata[31:24] == 8'd0) ? 8'd1 : s_tdata[31:24];
            stage_next   = i2cm_pkg::STG_ADDR;
            nack_next    = 1'b0;
            phase_next   = '0;
            bit_next     = '0;
            shift_next   = '0;
            step_next    = i2cm_pkg::ST_START0;
        end

        if (step_next != i2cm_pkg::ST_IDLE) begin
            res_next.busy = 1'b1;
            last_byte     = !(left_next > 8'd1);
            unique case (step_next)
                i2cm_pkg::ST_START0:   lv = '{1'b1, 1'b1, 1'b1};
                i2cm_pkg::ST_START1:   lv = '{1'b1, 1'b0, 1'b1};
                i2cm_pkg::ST_START2:   lv = '{1'b0, 1'b0, 1'b1};
                i2cm_pkg::ST_TX_SET:   lv = '{1'b0, shift_next[7], 1'b1};
                i2cm_pkg::ST_TX_HIGH:  lv = '{1'b1, shift_next[7], 1'b1};
                i2cm_pkg::ST_TX_LOW:   lv = '{1'b0, (bit_next == 3'd7) | shift_next[7], 1'b1};
                i2cm_pkg::ST_ACK_REL:  lv = '{1'b0, 1'b1, 1'b0};
                i2cm_pkg::ST_ACK_HIGH: lv = '{1'b1, 1'b1, 1'b0};
                i2cm_pkg::ST_ACK_LOW:  lv = '{1'b0, 1'b1, 1'b1};
                i2cm_pkg::ST_RX_REL:   lv = '{1'b0, 1'b1, 1'b0};
                i2cm_pkg::ST_RX_HIGH:  lv = '{1'b1, 1'b1, 1'b0};
                i2cm_pkg::ST_RX_LOW:   lv = '{1'b0, 1'b1, 1'b0};
                i2cm_pkg::ST_RX_DRIVE: lv = '{1'b0, 1'b1, 1'b1};
                i2cm_pkg::ST_MA_SET:   lv = '{1'b0, last_byte, 1'b1};
                i2cm_pkg::ST_MA_HIGH:  lv = '{1'b1, last_byte, 1'b1};
                i2cm_pkg::ST_MA_LOW:   lv = '{1'b0, last_byte, 1'b1};
                i2cm_pkg::ST_STOP:     lv = '{1'b1, 1'b0, 1'b1};
                default:               lv = lines_reg;
            endcase
            lines_next = lv;
            phase_inc  = phase_next + 10'd1;
            phase_next = phase_inc;

            if (phase_inc >= limit) begin
                phase_next = '0;
                unique case (step_next)
                    i2cm_pkg::ST_START0: step_next = i2cm_pkg::ST_START1;
                    i2cm_pkg::ST_START1: step_next = i2cm_pkg::ST_START2;
                    i2cm_pkg::ST_START2: begin
                        shift_next = (stage_next == i2cm_pkg::STG_RADDR) ?
                                     (dev_next | i2cm_pkg::ADDR_READ_BIT) : dev_next;
                        bit_next   = '0;
                        step_next  = i2cm_pkg::ST_TX_SET;
                    end
                    i2cm_pkg::ST_TX_SET:  step_next = i2cm_pkg::ST_TX_HIGH;
                    i2cm_pkg::ST_TX_HIGH: step_next = i2cm_pkg::ST_TX_LOW;
                    i2cm_pkg::ST_TX_LOW: begin
                        shift_next = {shift_next[6:0], 1'b0};
                        if (bit_next == 3'd7) begin
                            step_next = i2cm_pkg::ST_ACK_REL;
                        end else begin
                            bit_next  = bit_next + 3'd1;
                            step_next = i2cm_pkg::ST_TX_SET;
                        end
                    end
                    i2cm_pkg::ST_ACK_REL: step_next = i2cm_pkg::ST_ACK_HIGH;
                    i2cm_pkg::ST_ACK_HIGH: begin
                        nack_next = sda_in;
                        step_next = i2cm_pkg::ST_ACK_LOW;
                    end
                    i2cm_pkg::ST_ACK_LOW: begin
                        if (nack_next) begin
                            res_next.done = 1'b1;
                            lines_next    = i2cm_pkg::LINES_NACK;
                            step_next     = i2cm_pkg::ST_IDLE;
                        end else begin
                            unique case (stage_next)
                                i2cm_pkg::STG_ADDR: begin
                                    stage_next = i2cm_pkg::STG_REG;
                                    shift_next = regaddr_next;
                                    bit_next   = '0;
                                    step_next  = i2cm_pkg::ST_TX_SET;
                                end
                                i2cm_pkg::STG_REG: begin
                                    if (rd_next) begin
                                        stage_next = i2cm_pkg::STG_RADDR;
                                        step_next  = i2cm_pkg::ST_START0;
                                    end else begin
                                        stage_next = i2cm_pkg::STG_DATA;
                                        shift_next = wdata_next;
                                        bit_next   = '0;
                                        step_next  = i2cm_pkg::ST_TX_SET;
                                    end
                                end
                                i2cm_pkg::STG_DATA: step_next = i2cm_pkg::ST_STOP;
                                default: begin
                                    bit_next   = '0;
                                    shift_next = '0;
                                    step_next  = i2cm_pkg::ST_RX_REL;
                                end
                            endcase
                        end
                    end
                    i2cm_pkg::ST_RX_REL: step_next = i2cm_pkg::ST_RX_HIGH;
                    i2cm_pkg::ST_RX_HIGH: begin
                        shift_next = {shift_next[6:0], sda_in};
                        if (bit_next == 3'd7) begin
                            res_next.read_byte  = shift_next;
                            res_next.read_valid = 1'b1;
                        end
                        step_next = i2cm_pkg::ST_RX_LOW;
                    end
                    i2cm_pkg::ST_RX_LOW: begin
                        if (bit_next == 3'd7) begin
                            step_next = i2cm_pkg::ST_RX_DRIVE;
                        end else begin
                            bit_next  = bit_next + 3'd1;
                            step_next = i2cm_pkg::ST_RX_HIGH;
                        end
                    end
                    i2cm_pkg::ST_RX_DRIVE: step_next = i2cm_pkg::ST_MA_SET;
                    i2cm_pkg::ST_MA_SET:   step_next = i2cm_pkg::ST_MA_HIGH;
                    i2cm_pkg::ST_MA_HIGH:  step_next = i2cm_pkg::ST_MA_LOW;
                    i2cm_pkg::ST_MA_LOW: begin
                        if (!last_byte) begin
                            left_next  = left_next - 8'd1;
                            bit_next   = '0;
                            shift_next = '0;
                            step_next  = i2cm_pkg::ST_RX_REL;
                        end else begin
                            step_next = i2cm_pkg::ST_STOP;
                        end
                    end
                    i2cm_pkg::ST_STOP: begin
                        res_next.done    = 1'b1;
                        res_next.success = 1'b1;
                        lines_next       = i2cm_pkg::LINES_REST;
                        step_next        = i2cm_pkg::ST_IDLE;
                    end
                    default: step_next = i2cm_pkg::ST_IDLE;
                endcase
            end
        end

        res_next.scl_level = lv.scl;
        res_next.sda_level = lv.sda;
        res_next.sda_drive = lv.drv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg   <= 10'd1;
            step_reg    <= i2cm_pkg::ST_IDLE;
            phase_reg   <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            left_reg    <= '0;
            dev_reg     <= '0;
            regaddr_reg <= '0;
            wdata_reg   <= '0;
            rd_reg      <= 1'b0;
            lines_reg   <= i2cm_pkg::LINES_REST;
            stage_reg   <= i2cm_pkg::STG_ADDR;
            nack_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ticks_reg <= cfg_wr_data;
            end
            if (accept) begin
                step_reg    <= step_next;
                phase_reg   <= phase_next;
                bit_reg     <= bit_next;
                shift_reg   <= shift_next;
                left_reg    <= left_next;
                dev_reg     <= dev_next;
                regaddr_reg <= regaddr_next;
                wdata_reg   <= wdata_next;
                rd_reg      <= rd_next;
                lines_reg   <= lines_next;
                stage_reg   <= stage_next;
                nack_reg    <= nack_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_next.done) |=> (step_reg == i2cm_pkg::ST_IDLE))
        else $error("sequencer not idle after done");

    a_idle_phase_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == i2cm_pkg::ST_IDLE) |-> (phase_reg == 10'd0))
        else $error("phase count not cleared while idle");

    a_bytes_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != i2cm_pkg::ST_IDLE) |-> (left_reg != 8'd0))
        else $error("byte count reached zero in a transaction");

    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!(res_reg.read_valid && res_reg.done) &&
                         (!res_reg.success || res_reg.done) &&
                         (!res_reg.done || res_reg.busy)))
        else $error("inconsistent result flags");

endmodule
